// ===== rtl/cpa_pkg.sv =====
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared constants and types for the core partition allocator: action and
// status codes, field widths, parameter defaults and the scan-unit bundles.
// ----------------------------------------------------------------------------
package cpa_pkg;

	// parameter defaults
	localparam int N_CORES_DEF      = 4;
	localparam int CONTEXT_BITS_DEF = 4;

	// fixed field widths
	localparam int ACTION_W = 3;
	localparam int CTX_W    = 4;
	localparam int COUNT_W  = 5;
	localparam int CORE_W   = 4;
	localparam int MASK_W   = 16;
	localparam int STATUS_W = 2;
	localparam int CTX_MAX_W = 8;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_ALLOC   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_V2P     = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_P2V     = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_LIST    = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

	// control from the sequencer to the scan unit
	typedef struct packed {
		logic                 clear;
		logic                 step;
		logic [COUNT_W-1:0]   count;
		logic [CTX_MAX_W-1:0] ctx;
		logic [CORE_W-1:0]    index;
		logic [MASK_W-1:0]    list;
	} scan_ctl_t;

	// accumulated results of one pass over the owner table
	typedef struct packed {
		logic [COUNT_W-1:0] free_cnt;
		logic [COUNT_W-1:0] own_cnt;
		logic [COUNT_W-1:0] below_cnt;
		logic [MASK_W-1:0]  grant;
		logic [MASK_W-1:0]  owned;
		logic [MASK_W-1:0]  lmask;
		logic               found;
		logic [CORE_W-1:0]  phys;
	} scan_acc_t;

endpackage

// ===== rtl/cpa_owner_tbl.sv =====
// ----------------------------------------------------------------------------
// cpa_owner_tbl
// Owner table: one context entry per physical core, zero when free.
// One read port and one write port, both addressed by the core index.
// ----------------------------------------------------------------------------
module cpa_owner_tbl #(
	parameter int N_CORES      = cpa_pkg::N_CORES_DEF,
	parameter int CONTEXT_BITS = cpa_pkg::CONTEXT_BITS_DEF,
	localparam int IW = (N_CORES > 1) ? $clog2(N_CORES) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [IW-1:0]           rd_idx,
	output logic [CONTEXT_BITS-1:0] rd_data,
	input  logic                    wr_en,
	input  logic [IW-1:0]           wr_idx,
	input  logic [CONTEXT_BITS-1:0] wr_data
);

	logic [CONTEXT_BITS-1:0] owner_q [N_CORES];

	// entry storage, all cores free after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_CORES; i++) begin
				owner_q[i] <= '0;
			end
		end else if (wr_en) begin
			owner_q[wr_idx] <= wr_data;
		end
	end

	// read at the scan position
	assign rd_data = owner_q[rd_idx];

endmodule

// ===== rtl/cpa_scan.sv =====
// ----------------------------------------------------------------------------
// cpa_scan
// Shared per-core compare and count unit. Each step looks at one owner
// entry and updates free count, ownership rank, grant and translation masks.
// ----------------------------------------------------------------------------
module cpa_scan #(
	parameter int N_CORES      = cpa_pkg::N_CORES_DEF,
	parameter int CONTEXT_BITS = cpa_pkg::CONTEXT_BITS_DEF,
	localparam int IW = (N_CORES > 1) ? $clog2(N_CORES) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cpa_pkg::scan_ctl_t      ctl,
	input  logic [IW-1:0]           idx,
	input  logic [CONTEXT_BITS-1:0] owner,
	output cpa_pkg::scan_acc_t      acc
);

	cpa_pkg::scan_acc_t         acc_q;
	logic [cpa_pkg::COUNT_W-1:0] left_q;
	logic                        is_free;
	logic                        is_own;
	logic [cpa_pkg::CORE_W-1:0]  cidx;
	logic [cpa_pkg::COUNT_W-1:0] cidx_w;
	logic [cpa_pkg::COUNT_W-1:0] index_w;

	// compare the entry against free and against the requesting context
	assign is_free = (owner == '0);
	assign is_own  = (cpa_pkg::CTX_MAX_W'(owner) == ctl.ctx);
	assign cidx    = cpa_pkg::CORE_W'(idx);
	assign cidx_w  = cpa_pkg::COUNT_W'(idx);
	assign index_w = cpa_pkg::COUNT_W'(ctl.index);

	// accumulators for one pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			left_q <= '0;
		end else if (ctl.clear) begin
			acc_q  <= '0;
			left_q <= ctl.count;
		end else if (ctl.step) begin
			if (is_free) begin
				acc_q.free_cnt <= acc_q.free_cnt + 1'b1;
				if (left_q != '0) begin
					acc_q.grant[cidx] <= 1'b1;
					left_q            <= left_q - 1'b1;
				end
			end
			if (is_own) begin
				acc_q.owned[cidx] <= 1'b1;
				acc_q.own_cnt     <= acc_q.own_cnt + 1'b1;
				// virtual rank of this core is the owned count so far
				if (acc_q.own_cnt == index_w) begin
					acc_q.found <= 1'b1;
					acc_q.phys  <= cidx;
				end
				if (ctl.list[acc_q.own_cnt[cpa_pkg::CORE_W-1:0]]) begin
					acc_q.lmask[cidx] <= 1'b1;
				end
				if (cidx_w < index_w) begin
					acc_q.below_cnt <= acc_q.below_cnt + 1'b1;
				end
			end
		end
	end

	assign acc = acc_q;

endmodule

// ===== rtl/core_partition_allocator.sv =====
// ----------------------------------------------------------------------------
// core_partition_allocator
// Owner table of physical cores with allocate, release and virtual/physical
// core translation, run by a small sequencer over one shared scan unit.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  request  | start / busy     | action, context_id, core_count, core_index,
//           |                  | virt_list
//  result   | done (1 cycle)   | status, core_result, core_mask, free_count
//
//  A transaction is taken when start is high and busy is low. The scan unit
//  visits one core per cycle in a read pass, followed by a decide state.
//  A granted allocate or a release then adds a write pass through the owner
//  table's single write port; translations and refused requests do not.
//  Reset frees all cores. The result is shown for one cycle with done and
//  cannot be held off; busy drops in that same cycle.
// ----------------------------------------------------------------------------
module core_partition_allocator #(
	parameter int N_CORES      = cpa_pkg::N_CORES_DEF,
	parameter int CONTEXT_BITS = cpa_pkg::CONTEXT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [cpa_pkg::ACTION_W-1:0]   action,
	input  logic [cpa_pkg::CTX_W-1:0]      context_id,
	input  logic [cpa_pkg::COUNT_W-1:0]    core_count,
	input  logic [cpa_pkg::CORE_W-1:0]     core_index,
	input  logic [cpa_pkg::MASK_W-1:0]     virt_list,
	output logic                           done,
	output logic [cpa_pkg::STATUS_W-1:0]   status,
	output logic [cpa_pkg::CORE_W-1:0]     core_result,
	output logic [cpa_pkg::MASK_W-1:0]     core_mask,
	output logic [cpa_pkg::COUNT_W-1:0]    free_count
);

	localparam int IW = (N_CORES > 1) ? $clog2(N_CORES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(N_CORES - 1);
	localparam logic [cpa_pkg::COUNT_W-1:0] NCORES_W = cpa_pkg::COUNT_W'(N_CORES);

	// sequencer states
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DECIDE = 2'd2;
	localparam logic [1:0] S_COMMIT = 2'd3;

	logic [1:0]                      state_q;
	logic [IW-1:0]                   idx_q;
	logic [cpa_pkg::ACTION_W-1:0]    action_q;
	logic [cpa_pkg::CTX_W-1:0]       ctx_q;
	logic [cpa_pkg::COUNT_W-1:0]     count_q;
	logic [cpa_pkg::CORE_W-1:0]      index_q;
	logic [cpa_pkg::MASK_W-1:0]      list_q;
	logic [cpa_pkg::MASK_W-1:0]      wmask_q;
	logic                            walloc_q;
	logic                            done_q;
	logic [cpa_pkg::STATUS_W-1:0]    status_q;
	logic [cpa_pkg::CORE_W-1:0]      result_q;
	logic [cpa_pkg::MASK_W-1:0]      mask_q;
	logic [cpa_pkg::COUNT_W-1:0]     free_q;

	logic                            accept;
	logic                            last;
	cpa_pkg::scan_ctl_t              ctl;
	cpa_pkg::scan_acc_t              acc;
	logic [CONTEXT_BITS-1:0]         rd_owner;
	logic                            wr_en;
	logic [CONTEXT_BITS-1:0]         wr_data;

	logic                            bad_ctx;
	logic [cpa_pkg::STATUS_W-1:0]    dec_status;
	logic [cpa_pkg::CORE_W-1:0]      dec_result;
	logic [cpa_pkg::MASK_W-1:0]      dec_mask;
	logic                            dec_commit;
	logic                            dec_alloc;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign last   = (idx_q == LAST_IDX);

	// scan unit control
	always_comb begin
		ctl       = '0;
		ctl.clear = accept;
		ctl.step  = (state_q == S_SCAN);
		ctl.count = core_count;
		ctl.ctx   = cpa_pkg::CTX_MAX_W'(ctx_q);
		ctl.index = index_q;
		ctl.list  = list_q;
	end

	cpa_owner_tbl #(
		.N_CORES      (N_CORES),
		.CONTEXT_BITS (CONTEXT_BITS)
	) u_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (idx_q),
		.rd_data (rd_owner),
		.wr_en   (wr_en),
		.wr_idx  (idx_q),
		.wr_data (wr_data)
	);

	cpa_scan #(
		.N_CORES      (N_CORES),
		.CONTEXT_BITS (CONTEXT_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.idx    (idx_q),
		.owner  (rd_owner),
		.acc    (acc)
	);

	// write pass: claim granted cores or free released ones
	assign wr_en   = (state_q == S_COMMIT) && wmask_q[cpa_pkg::CORE_W'(idx_q)];
	assign wr_data = walloc_q ? CONTEXT_BITS'(ctx_q) : '0;

	// outcome from the finished scan
	always_comb begin
		bad_ctx    = (ctx_q == '0) || ((32'(ctx_q) >> CONTEXT_BITS) != 32'd0);
		dec_status = cpa_pkg::ST_OK;
		dec_result = '0;
		dec_mask   = '0;
		dec_commit = 1'b0;
		dec_alloc  = 1'b0;
		if (bad_ctx) begin
			dec_status = cpa_pkg::ST_INVALID;
		end else begin
			case (action_q)
				cpa_pkg::ACT_ALLOC: begin
					if (count_q == '0 || count_q > NCORES_W) begin
						dec_status = cpa_pkg::ST_INVALID;
					end else if (acc.free_cnt < count_q) begin
						dec_status = cpa_pkg::ST_BUSY;
					end else begin
						dec_mask   = acc.grant;
						dec_commit = 1'b1;
						dec_alloc  = 1'b1;
					end
				end
				cpa_pkg::ACT_RELEASE: begin
					dec_mask   = acc.owned;
					dec_commit = 1'b1;
				end
				cpa_pkg::ACT_V2P: begin
					if (acc.found) begin
						dec_result = acc.phys;
						dec_mask   = cpa_pkg::MASK_W'(1) << acc.phys;
					end else begin
						dec_status = cpa_pkg::ST_INVALID;
					end
				end
				cpa_pkg::ACT_P2V: begin
					if (cpa_pkg::COUNT_W'(index_q) < NCORES_W && acc.owned[index_q]) begin
						dec_result = cpa_pkg::CORE_W'(acc.below_cnt);
						dec_mask   = cpa_pkg::MASK_W'(1) << index_q;
					end else begin
						dec_status = cpa_pkg::ST_INVALID;
					end
				end
				cpa_pkg::ACT_LIST: begin
					// any listed virtual core beyond the owned count is unmapped
					if ((32'(list_q) >> acc.own_cnt) != 32'd0) begin
						dec_status = cpa_pkg::ST_INVALID;
					end else begin
						dec_mask = acc.lmask;
					end
				end
				default: begin
					dec_status = cpa_pkg::ST_INVALID;
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ((state_q == S_DECIDE) && !dec_commit) ||
				((state_q == S_COMMIT) && last);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (last) begin
						state_q <= S_DECIDE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DECIDE: begin
					idx_q <= '0;
					if (dec_commit) begin
						state_q <= S_COMMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_COMMIT: begin
					if (last) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			ctx_q    <= context_id;
			count_q  <= core_count;
			index_q  <= core_index;
			list_q   <= virt_list;
		end
	end

	// result and write-pass registers
	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE) begin
			status_q <= dec_status;
			result_q <= dec_result;
			mask_q   <= dec_mask;
			free_q   <= acc.free_cnt;
			wmask_q  <= dec_mask;
			walloc_q <= dec_alloc;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign core_result = result_q;
	assign core_mask   = mask_q;
	assign free_count  = free_q;

endmodule

// ===== dv/cpa_checker.sv =====
// ----------------------------------------------------------------------------
// cpa_checker
// Watches the request and result channels of the core partition allocator,
// keeps its own copy of the core owner table, predicts the reply to every
// accepted request and compares each reply, field by field, in order.
// ----------------------------------------------------------------------------
module cpa_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic [cpa_pkg::ACTION_W-1:0] action,
	input  logic [cpa_pkg::CTX_W-1:0]    context_id,
	input  logic [cpa_pkg::COUNT_W-1:0]  core_count,
	input  logic [cpa_pkg::CORE_W-1:0]   core_index,
	input  logic [cpa_pkg::MASK_W-1:0]   virt_list,
	input  logic                         done,
	input  logic [cpa_pkg::STATUS_W-1:0] status,
	input  logic [cpa_pkg::CORE_W-1:0]   core_result,
	input  logic [cpa_pkg::MASK_W-1:0]   core_mask,
	input  logic [cpa_pkg::COUNT_W-1:0]  free_count,
	output int                           fail_count,
	output int                           replies_waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	import cpa_pkg::*;

	localparam int NCORES    = N_CORES_DEF;
	localparam int CTX_LIMIT = 1 << CONTEXT_BITS_DEF;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CORE_W-1:0]   core;
		logic [MASK_W-1:0]   mask;
		logic [COUNT_W-1:0]  free_cnt;
	} core_reply_t;

	// model owner table: context per physical core, zero when free
	logic [CTX_W-1:0] core_owner [NCORES];
	core_reply_t      replies_due [$];
	int               n_fail = 0;

	// physical core of the ctx's v-th owned core, -1 if unmapped
	function automatic int phys_of(logic [CTX_W-1:0] ctx, int v);
		int k;
		k = 0;
		for (int c = 0; c < NCORES; c++) begin
			if (core_owner[c] == ctx) begin
				if (k == v)
					return c;
				k++;
			end
		end
		return -1;
	endfunction

	// reply to one request, with its effect on the owner table
	function automatic core_reply_t apply_request(
		logic [ACTION_W-1:0] act,
		logic [CTX_W-1:0]    ctx,
		logic [COUNT_W-1:0]  cnt,
		logic [CORE_W-1:0]   idx,
		logic [MASK_W-1:0]   lst
	);
		core_reply_t r;
		int          left;
		int          p;
		int          k;
		r = '0;
		r.status = ST_OK;
		for (int c = 0; c < NCORES; c++)
			if (core_owner[c] == '0)
				r.free_cnt = r.free_cnt + 1'b1;
		if (ctx == '0 || int'(ctx) >= CTX_LIMIT) begin
			r.status = ST_INVALID;
			return r;
		end
		case (act)
			ACT_ALLOC: begin
				if (cnt == '0 || int'(cnt) > NCORES) begin
					r.status = ST_INVALID;
				end else if (r.free_cnt < cnt) begin
					r.status = ST_BUSY;
				end else begin
					left = int'(cnt);
					for (int c = 0; c < NCORES && left > 0; c++) begin
						if (core_owner[c] == '0) begin
							core_owner[c] = ctx;
							r.mask[c] = 1'b1;
							left--;
						end
					end
				end
			end
			ACT_RELEASE: begin
				for (int c = 0; c < NCORES; c++) begin
					if (core_owner[c] == ctx) begin
						r.mask[c] = 1'b1;
						core_owner[c] = '0;
					end
				end
			end
			ACT_V2P: begin
				p = phys_of(ctx, int'(idx));
				if (p < 0) begin
					r.status = ST_INVALID;
				end else begin
					r.core = CORE_W'(p);
					r.mask[p] = 1'b1;
				end
			end
			ACT_P2V: begin
				if (int'(idx) >= NCORES || core_owner[idx] != ctx) begin
					r.status = ST_INVALID;
				end else begin
					k = 0;
					for (int c = 0; c < idx; c++)
						if (core_owner[c] == ctx)
							k++;
					r.core = CORE_W'(k);
					r.mask[idx] = 1'b1;
				end
			end
			ACT_LIST: begin
				for (int v = 0; v < MASK_W; v++) begin
					if (lst[v]) begin
						p = phys_of(ctx, v);
						if (p < 0) begin
							r.status = ST_INVALID;
							r.mask = '0;
							break;
						end
						r.mask[p] = 1'b1;
					end
				end
			end
			default: r.status = ST_INVALID;
		endcase
		return r;
	endfunction

	task automatic check_field(string name, logic [MASK_W-1:0] exp_v,
		logic [MASK_W-1:0] got);
		if (exp_v !== got) begin
			n_fail++;
			$display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h",
				$time, name, exp_v, got);
		end
	endtask

	// compare finished transactions first, then predict the newly accepted one
	always @(posedge clk or negedge arst_n) begin
		core_reply_t exp_r;
		if (!arst_n) begin
			for (int c = 0; c < NCORES; c++)
				core_owner[c] = '0;
			replies_due.delete();
		end else begin
			if (done) begin
				if (replies_due.size() == 0) begin
					n_fail++;
					$display("%0t: result with no transaction pending: %s %0d mask 0x%0h",
						$time, "expected none, got status", status, core_mask);
				end else begin
					exp_r = replies_due.pop_front();
					check_field("status", MASK_W'(exp_r.status), MASK_W'(status));
					check_field("core_result", MASK_W'(exp_r.core), MASK_W'(core_result));
					check_field("core_mask", exp_r.mask, core_mask);
					check_field("free_count", MASK_W'(exp_r.free_cnt), MASK_W'(free_count));
				end
			end
			if (start && !busy)
				replies_due.push_back(apply_request(action, context_id, core_count,
					core_index, virt_list));
		end
		replies_waiting <= replies_due.size();
		fail_count <= n_fail;
	end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Top of the core partition allocator testbench: a directed pass over the
// refusal, translation and reuse cases, then random requests biased toward a
// few contexts so cores are shared, released and translated often. Replies
// are checked by cpa_checker; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cpa_pkg::*;

	localparam int N_RANDOM    = 1400;
	localparam int STALL_LIMIT = 500;
	localparam int DRAIN       = 30;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [ACTION_W-1:0] action = '0;
	logic [CTX_W-1:0]    context_id = '0;
	logic [COUNT_W-1:0]  core_count = '0;
	logic [CORE_W-1:0]   core_index = '0;
	logic [MASK_W-1:0]   virt_list = '0;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [CORE_W-1:0]   core_result;
	logic [MASK_W-1:0]   core_mask;
	logic [COUNT_W-1:0]  free_count;
	int                  fail_count;
	int                  replies_waiting;
	int                  idle_pct = 27;
	int                  quiet_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	core_partition_allocator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .context_id(context_id), .core_count(core_count),
		.core_index(core_index), .virt_list(virt_list),
		.done(done), .status(status), .core_result(core_result),
		.core_mask(core_mask), .free_count(free_count)
	);

	cpa_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .context_id(context_id), .core_count(core_count),
		.core_index(core_index), .virt_list(virt_list),
		.done(done), .status(status), .core_result(core_result),
		.core_mask(core_mask), .free_count(free_count),
		.fail_count(fail_count), .replies_waiting(replies_waiting)
	);

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// present one request, with random idle cycles ahead of it, until taken
	task automatic send(logic [ACTION_W-1:0] a, logic [CTX_W-1:0] ctx,
		logic [COUNT_W-1:0] cnt, logic [CORE_W-1:0] idx, logic [MASK_W-1:0] lst);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= a;
		context_id <= ctx;
		core_count <= cnt;
		core_index <= idx;
		virt_list <= lst;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// random request, mostly well formed and over a few shared contexts
	task automatic send_random();
		logic [ACTION_W-1:0] a;
		logic [CTX_W-1:0]    ctx;
		logic [COUNT_W-1:0]  cnt;
		logic [CORE_W-1:0]   idx;
		logic [MASK_W-1:0]   lst;
		int                  pick;
		pick = $urandom_range(99);
		if (pick < 28)
			a = ACT_ALLOC;
		else if (pick < 45)
			a = ACT_RELEASE;
		else if (pick < 63)
			a = ACT_V2P;
		else if (pick < 80)
			a = ACT_P2V;
		else if (pick < 95)
			a = ACT_LIST;
		else
			a = ACTION_W'($urandom_range(7, ACT_LIST + 1));
		pick = $urandom_range(99);
		if (pick < 3)
			ctx = '0;
		else if (pick < 75)
			ctx = CTX_W'($urandom_range(4, 1));
		else
			ctx = CTX_W'($urandom_range(15, 1));
		cnt = ($urandom_range(9) < 8) ? COUNT_W'($urandom_range(4, 1))
			: COUNT_W'($urandom_range(31));
		idx = ($urandom_range(9) < 8) ? CORE_W'($urandom_range(3)) : CORE_W'($urandom);
		lst = ($urandom_range(9) < 7) ? {12'd0, 4'($urandom)} : 16'($urandom);
		send(a, ctx, cnt, idx, lst);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: refusals and an empty release on an empty table
		send(ACT_V2P, 4'd1, 5'd0, 4'd0, 16'h0000);
		send(ACT_RELEASE, 4'd2, 5'd0, 4'd0, 16'h0000);
		send(ACT_ALLOC, 4'd0, 5'd1, 4'd0, 16'h0000);
		send(ACT_ALLOC, 4'd3, 5'd0, 4'd0, 16'h0000);
		send(ACT_ALLOC, 4'd3, 5'd5, 4'd0, 16'h0000);
		send(ACT_ALLOC, 4'd3, 5'd16, 4'd0, 16'h0000);
		send(ACT_ALLOC, 4'd3, 5'd31, 4'd15, 16'hffff);
		// directed: fill the table, repeat allocate, then run out
		send(ACT_ALLOC, 4'd3, 5'd2, 4'd0, 16'h0000);
		send(ACT_ALLOC, 4'd5, 5'd1, 4'd0, 16'h0000);
		send(ACT_ALLOC, 4'd3, 5'd1, 4'd0, 16'h0000);
		send(ACT_ALLOC, 4'd7, 5'd1, 4'd0, 16'h0000);
		// directed: translations over a split ownership
		send(ACT_V2P, 4'd3, 5'd0, 4'd2, 16'h0000);
		send(ACT_V2P, 4'd3, 5'd0, 4'd3, 16'h0000);
		send(ACT_V2P, 4'd3, 5'd0, 4'd15, 16'h0000);
		send(ACT_P2V, 4'd3, 5'd0, 4'd3, 16'h0000);
		send(ACT_P2V, 4'd3, 5'd0, 4'd2, 16'h0000);
		send(ACT_P2V, 4'd3, 5'd0, 4'd15, 16'h0000);
		send(ACT_LIST, 4'd3, 5'd0, 4'd0, 16'h0007);
		send(ACT_LIST, 4'd3, 5'd0, 4'd0, 16'h0008);
		send(ACT_LIST, 4'd3, 5'd0, 4'd0, 16'h0000);
		send(ACT_LIST, 4'd3, 5'd0, 4'd0, 16'hffff);
		// unknown action codes
		for (int a = ACT_LIST + 1; a < (1 << ACTION_W); a++)
			send(ACTION_W'(a), 4'd3, 5'd1, 4'd0, 16'h0001);
		// directed: release into a hole and reuse it, then a full grant
		send(ACT_RELEASE, 4'd5, 5'd0, 4'd0, 16'h0000);
		send(ACT_ALLOC, 4'd15, 5'd1, 4'd0, 16'h0000);
		send(ACT_RELEASE, 4'd3, 5'd0, 4'd0, 16'h0000);
		send(ACT_RELEASE, 4'd15, 5'd0, 4'd0, 16'h0000);
		send(ACT_ALLOC, 4'd9, 5'd4, 4'd0, 16'h0000);
		send(ACT_RELEASE, 4'd9, 5'd0, 4'd0, 16'h0000);

		// random part, with a stretch of back-to-back requests
		for (int i = 0; i < N_RANDOM; i++) begin
			idle_pct = (i >= 500 && i < 700) ? 0 : 27;
			send_random();
		end
		start <= 1'b0;
		@(posedge clk);

		// drain
		while (replies_waiting != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
